// ===== rtl/bmp24w_pkg.sv =====
// ----------------------------------------------------------------------------
// bmp24w_pkg
// Shared types, constants and byte functions of the 24-bit BMP stream writer.
// ----------------------------------------------------------------------------
package bmp24w_pkg;

    // Header layout constants
    localparam int unsigned HdrBytes      = 54;
    localparam logic [15:0] BmpType       = 16'h4D42;
    localparam logic [7:0]  PixelOffset   = 8'd54;
    localparam logic [7:0]  InfoHdrSize   = 8'd40;
    localparam logic [7:0]  BitsPerPixel  = 8'd24;
    localparam logic [7:0]  NumPlanes     = 8'd1;
    localparam logic [7:0]  ChanMax       = 8'd255;
    localparam logic [15:0] ChanOne       = 16'd4096;

    // Byte positions within one item: header, then blue, green, red, padding
    localparam logic [5:0]  PosFirst      = 6'd0;
    localparam logic [5:0]  PosBlue       = 6'd54;
    localparam logic [5:0]  PosGreen      = 6'd55;
    localparam logic [5:0]  PosRed        = 6'd56;

    // Header field byte offsets
    localparam logic [5:0]  OffType       = 6'd0;
    localparam logic [5:0]  OffSize       = 6'd2;
    localparam logic [5:0]  OffPixels     = 6'd10;
    localparam logic [5:0]  OffInfo       = 6'd14;
    localparam logic [5:0]  OffWidth      = 6'd18;
    localparam logic [5:0]  OffHeight     = 6'd22;
    localparam logic [5:0]  OffPlanes     = 6'd26;
    localparam logic [5:0]  OffBits       = 6'd28;

    // Configuration register indexes
    localparam logic        RegWidth      = 1'b0;
    localparam logic        RegHeight     = 1'b1;

    // One pixel, converted, with what it needs around it
    typedef struct packed {
        logic       hdr;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic [1:0] pad;
        logic       img_end;
    } t_item;

    // Q4.12 channel to byte: clamp negative to 0, above 1.0 to 255
    function automatic logic [7:0] chan_to_byte(input logic [15:0] v);
        logic [20:0] prod;
        begin
            prod = ({8'd0, v[12:0]} << 8) - {8'd0, v[12:0]};
            if (v[15]) begin
                chan_to_byte = 8'd0;
            end else if (v > ChanOne) begin
                chan_to_byte = ChanMax;
            end else begin
                chan_to_byte = prod[19:12];
            end
        end
    endfunction

    // Header byte at a given position
    function automatic logic [7:0] hdr_byte(
        input logic [5:0]  idx,
        input logic [15:0] w,
        input logic [15:0] h,
        input logic [31:0] size
    );
        begin
            unique case (idx)
                OffType:          hdr_byte = BmpType[7:0];
                OffType + 6'd1:   hdr_byte = BmpType[15:8];
                OffSize:          hdr_byte = size[7:0];
                OffSize + 6'd1:   hdr_byte = size[15:8];
                OffSize + 6'd2:   hdr_byte = size[23:16];
                OffSize + 6'd3:   hdr_byte = size[31:24];
                OffPixels:        hdr_byte = PixelOffset;
                OffInfo:          hdr_byte = InfoHdrSize;
                OffWidth:         hdr_byte = w[7:0];
                OffWidth + 6'd1:  hdr_byte = w[15:8];
                OffHeight:        hdr_byte = h[7:0];
                OffHeight + 6'd1: hdr_byte = h[15:8];
                OffPlanes:        hdr_byte = NumPlanes;
                OffBits:          hdr_byte = BitsPerPixel;
                default:          hdr_byte = 8'd0;
            endcase
        end
    endfunction

endpackage

// ===== rtl/bmp24_pixel_stream_writer_core.sv =====
// ----------------------------------------------------------------------------
// bmp24_pixel_stream_writer_core
// Turns a stream of Q4.12 RGB pixels into the byte stream of a 24-bit BMP.
// ----------------------------------------------------------------------------
// One pixel beat in gives its blue, green and red bytes out, one byte per
// cycle unless i_m_tready stalls the output; the first pixel of an image
// adds the 54 header bytes and the last pixel of a row adds image_width
// mod 4 padding bytes. The single byte-wide output register sets this rate.
// A pixel is accepted into an input register while the previous one is
// still being sent. The last byte of each pixel carries tlast, the last
// byte of the file carries tuser. Write image_width and image_height only
// while the block is idle; a value of 0 counts as 65536 rows or columns.
module bmp24_pixel_stream_writer_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write port
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    // Pixel input
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [47:0] i_s_tdata,   // red[15:0], green[31:16], blue[47:32]
    // Byte output
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,   // data_byte[7:0]
    output logic        o_m_tlast,   // last_in_run
    output logic        o_m_tuser    // image_end
);
    import bmp24w_pkg::*;

    logic [15:0] r_width;
    logic [15:0] r_height;
    logic [31:0] r_size;
    logic [15:0] r_col;
    logic [15:0] r_row;
    logic        r_a_valid;
    t_item       r_a_item;

    logic        s_accept;
    logic        emit_ready;
    logic [16:0] eff_w;
    logic [16:0] eff_h;
    logic        row_end;
    logic        img_end;
    logic [17:0] row_bytes;
    logic [33:0] n_size;
    t_item       n_item;

    // Hold configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= 16'd1;
            r_height <= 16'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                RegWidth:  r_width  <= i_cfg_data;
                RegHeight: r_height <= i_cfg_data;
            endcase
        end
    end

    // File size from the raw register values, kept modulo 2^32
    assign row_bytes = ({2'd0, r_width} << 1) + {2'd0, r_width} + {16'd0, r_width[1:0]};
    assign n_size    = ({18'd0, r_height} * {16'd0, row_bytes}) + 34'(HdrBytes);

    always_ff @(posedge i_clk) begin
        r_size <= n_size[31:0];
    end

    // Row and image end against effective sizes
    assign eff_w   = (r_width  == 16'd0) ? 17'h10000 : {1'b0, r_width};
    assign eff_h   = (r_height == 16'd0) ? 17'h10000 : {1'b0, r_height};
    assign row_end = ({1'b0, r_col} + 17'd1) >= eff_w;
    assign img_end = row_end && (({1'b0, r_row} + 17'd1) >= eff_h);

    // Build the item for the incoming pixel
    always_comb begin
        n_item.hdr     = (r_col == 16'd0) && (r_row == 16'd0);
        n_item.red     = chan_to_byte(i_s_tdata[15:0]);
        n_item.green   = chan_to_byte(i_s_tdata[31:16]);
        n_item.blue    = chan_to_byte(i_s_tdata[47:32]);
        n_item.pad     = row_end ? r_width[1:0] : 2'd0;
        n_item.img_end = img_end;
    end

    assign o_s_tready = !r_a_valid || emit_ready;
    assign s_accept   = i_s_tvalid && o_s_tready;

    // Advance column and row counters on each accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= 16'd0;
            r_row <= 16'd0;
        end else if (s_accept) begin
            if (row_end) begin
                r_col <= 16'd0;
                r_row <= img_end ? 16'd0 : (r_row + 16'd1);
            end else begin
                r_col <= r_col + 16'd1;
            end
        end
    end

    // Hold the accepted pixel until the emitter takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else begin
            if (s_accept) begin
                r_a_valid <= 1'b1;
                r_a_item  <= n_item;
            end else if (emit_ready) begin
                r_a_valid <= 1'b0;
            end
        end
    end

    bmp24w_emitter u_emitter (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (r_a_valid),
        .o_ready    (emit_ready),
        .i_item     (r_a_item),
        .i_width    (r_width),
        .i_height   (r_height),
        .i_size     (r_size),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tuser  (o_m_tuser)
    );

endmodule

// ===== rtl/bmp24w_emitter.sv =====
// ----------------------------------------------------------------------------
// bmp24w_emitter
// Walks one held pixel item byte by byte (header, B, G, R, padding) into an
// output register.
// ----------------------------------------------------------------------------
module bmp24w_emitter (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  bmp24w_pkg::t_item  i_item,
    input  logic [15:0]        i_width,
    input  logic [15:0]        i_height,
    input  logic [31:0]        i_size,
    output logic               o_m_tvalid,
    input  logic               i_m_tready,
    output logic [7:0]         o_m_tdata,   // data_byte
    output logic               o_m_tlast,   // last_in_run
    output logic               o_m_tuser    // image_end
);
    import bmp24w_pkg::*;

    logic       r_seq_valid;
    t_item      r_item;
    logic [5:0] r_pos;
    logic       r_out_valid;
    logic [7:0] r_out_data;
    logic       r_out_last;
    logic       r_out_end;

    logic       out_adv;
    logic       seq_last;
    logic       take;
    logic [7:0] cur_byte;

    // Output register frees when empty or when its beat is taken
    assign out_adv  = !r_out_valid || i_m_tready;
    assign seq_last = (r_pos == (PosRed + {4'd0, r_item.pad}));
    assign o_ready  = !r_seq_valid || (out_adv && seq_last);
    assign take     = i_valid && o_ready;

    // Select the byte at the current position
    always_comb begin
        if (r_pos < PosBlue) begin
            cur_byte = hdr_byte(r_pos, i_width, i_height, i_size);
        end else if (r_pos == PosBlue) begin
            cur_byte = r_item.blue;
        end else if (r_pos == PosGreen) begin
            cur_byte = r_item.green;
        end else if (r_pos == PosRed) begin
            cur_byte = r_item.red;
        end else begin
            cur_byte = 8'd0;
        end
    end

    // Advance the sequencer and load the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_adv) begin
                r_out_valid <= r_seq_valid;
                r_out_data  <= cur_byte;
                r_out_last  <= seq_last;
                r_out_end   <= seq_last && r_item.img_end;
            end
            if (take) begin
                r_seq_valid <= 1'b1;
                r_item      <= i_item;
                r_pos       <= i_item.hdr ? PosFirst : PosBlue;
            end else if (r_seq_valid && out_adv) begin
                if (seq_last) begin
                    r_seq_valid <= 1'b0;
                end else begin
                    r_pos <= r_pos + 6'd1;
                end
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tlast  = r_out_last;
    assign o_m_tuser  = r_out_end;

endmodule
